[rtl/core/ipwc_pkg.sv]
// Shared types, codes and reset values for the IR pulse width capture block.
package ipwc_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned WCODE_W = 2;
   localparam int unsigned CAUSE_W = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;

   // Hard limit on buffer entries; larger capacity settings are clamped to it.
   localparam logic [COUNT_W-1:0] MAX_ENTRIES = COUNT_W'(1024);

   localparam logic [TIME_W-1:0]  SIGNAL_TIMEOUT_RST = TIME_W'(1000000);
   localparam logic [TIME_W-1:0]  PULSE_TIMEOUT_RST  = TIME_W'(100000);
   localparam logic [COUNT_W-1:0] CAPACITY_RST       = COUNT_W'(256);

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_ARM  = 1'b1
   } opcode_type;

   typedef enum logic {
      KIND_DURATION = 1'b0,
      KIND_FINISHED = 1'b1
   } kind_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_SIGNAL = 2'd0,
      CAUSE_PULSE  = 2'd1,
      CAUSE_FULL   = 2'd2
   } cause_type;

   typedef enum logic [WCODE_W-1:0] {
      WIDTH_BYTE  = 2'd0,
      WIDTH_HALF  = 2'd1,
      WIDTH_WORD  = 2'd2,
      WIDTH_RSVD  = 2'd3
   } width_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGNAL_TIMEOUT = 2'd0,
      CSR_PULSE_TIMEOUT  = 2'd1,
      CSR_ENTRY_WIDTH    = 2'd2,
      CSR_CAPACITY       = 2'd3
   } csr_index_type;

endpackage

[rtl/core/ir_pulse_width_capture.sv]
// Top level of the IR pulse width capture block.
//
// Measures the time between level changes of a sampled IR receiver pin.
// Each input item is either an arm (tuser = 1), which samples the starting
// level and clears the timers and entry count, or a tick (tuser = 0), one
// microsecond sample of the pin. On every edge while capturing, with room left
// and no timeout, one duration item leaves on rsp_ (tuser = 0) holding the time
// since the previous edge, truncated to the configured entry width, and its
// entry index. Capture ends with one finished item (tuser = 1) that carries the
// number of entries and the cause: total signal timeout, pulse timeout or buffer
// full. Ticks while idle and arms give no result. The state update and the
// result are formed in a single pass from the state registers into the result
// register, so an item is accepted in every cycle as long as the result
// register is empty or being drained. Configuration writes are taken at any
// time but must only be issued while no capture result is outstanding.
module ir_pulse_width_capture (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ipwc_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] pin_level, rest zero
   input  logic                                req_tuser,  // [0] opcode
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ipwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [31:0] duration_us,
                                                           // [42:32] entry_index,
                                                           // [44:43] end_cause, rest zero
   output logic                                rsp_tuser,  // [0] kind
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ipwc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ipwc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ipwc_pkg::*;

   // configuration
   logic [TIME_W-1:0]  signal_timeout_ff;
   logic [TIME_W-1:0]  pulse_timeout_ff;
   logic [WCODE_W-1:0] width_code_ff;
   logic [COUNT_W-1:0] capacity_ff;

   // capture state
   logic               capturing_ff, capturing_in;
   logic               level_ff, level_in;
   logic [TIME_W-1:0]  total_ff, total_in;
   logic [TIME_W-1:0]  pulse_ff, pulse_in;
   logic [COUNT_W-1:0] entries_ff, entries_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [TIME_W-1:0]  rsp_duration_ff, rsp_duration_in;
   logic [COUNT_W-1:0] rsp_index_ff, rsp_index_in;
   cause_type          rsp_cause_ff, rsp_cause_in;

   logic               accept;
   opcode_type         op;
   logic               pin;
   logic [TIME_W-1:0]  total_inc;
   logic [TIME_W-1:0]  pulse_inc;
   logic [COUNT_W-1:0] capacity_eff;
   logic [TIME_W-1:0]  duration_trunc;
   logic               emit;

   // result register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign op  = opcode_type'(req_tuser);
   assign pin = req_tdata[0];

   // saturating counters
   assign total_inc = (&total_ff) ? total_ff : total_ff + TIME_W'(1);
   assign pulse_inc = (&pulse_ff) ? pulse_ff : pulse_ff + TIME_W'(1);

   assign capacity_eff = (capacity_ff > MAX_ENTRIES) ? MAX_ENTRIES : capacity_ff;

   always_comb begin
      unique case (width_code_type'(width_code_ff))
         WIDTH_BYTE: duration_trunc = {{(TIME_W-8){1'b0}}, pulse_inc[7:0]};
         WIDTH_HALF: duration_trunc = {{(TIME_W-16){1'b0}}, pulse_inc[15:0]};
         default:    duration_trunc = pulse_inc;   // word, reserved code too
      endcase
   end

   // one pass: state update and result for the accepted item
   always_comb begin
      capturing_in    = capturing_ff;
      level_in        = level_ff;
      total_in        = total_ff;
      pulse_in        = pulse_ff;
      entries_in      = entries_ff;
      emit            = 1'b0;
      rsp_kind_in     = KIND_DURATION;
      rsp_duration_in = '0;
      rsp_index_in    = entries_ff;
      rsp_cause_in    = CAUSE_SIGNAL;

      if (accept) begin
         if (op == OP_ARM) begin
            capturing_in = 1'b1;
            level_in     = pin;
            total_in     = '0;
            pulse_in     = '0;
            entries_in   = '0;
         end else if (capturing_ff) begin
            total_in = total_inc;
            pulse_in = pulse_inc;
            priority if (total_inc >= signal_timeout_ff) begin
               capturing_in = 1'b0;
               emit         = 1'b1;
               rsp_kind_in  = KIND_FINISHED;
               rsp_cause_in = CAUSE_SIGNAL;
            end else if (pulse_inc >= pulse_timeout_ff) begin
               capturing_in = 1'b0;
               emit         = 1'b1;
               rsp_kind_in  = KIND_FINISHED;
               rsp_cause_in = CAUSE_PULSE;
            end else if (pin == level_ff) begin
               emit = 1'b0;
            end else if (entries_ff >= capacity_eff) begin
               capturing_in = 1'b0;
               emit         = 1'b1;
               rsp_kind_in  = KIND_FINISHED;
               rsp_cause_in = CAUSE_FULL;
            end else begin
               emit            = 1'b1;
               rsp_duration_in = duration_trunc;
               entries_in      = entries_ff + COUNT_W'(1);
               pulse_in        = '0;
               level_in        = pin;
            end
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         signal_timeout_ff <= SIGNAL_TIMEOUT_RST;
         pulse_timeout_ff  <= PULSE_TIMEOUT_RST;
         width_code_ff     <= WIDTH_HALF;
         capacity_ff       <= CAPACITY_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIGNAL_TIMEOUT: signal_timeout_ff <= csr_data;
            CSR_PULSE_TIMEOUT:  pulse_timeout_ff  <= csr_data;
            CSR_ENTRY_WIDTH:    width_code_ff     <= csr_data[WCODE_W-1:0];
            CSR_CAPACITY:       capacity_ff       <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         level_ff     <= 1'b0;
         total_ff     <= '0;
         pulse_ff     <= '0;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capturing_ff <= capturing_in;
         level_ff     <= level_in;
         total_ff     <= total_in;
         pulse_ff     <= pulse_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only with a new result
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff     <= rsp_kind_in;
         rsp_duration_ff <= rsp_duration_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_cause_ff    <= rsp_cause_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TIME_W-COUNT_W-CAUSE_W){1'b0}},
                        rsp_cause_ff, rsp_index_ff, rsp_duration_ff};

endmodule

[rtl/core/ipwc_checker.sv]
// Port-level checks for the IR pulse width capture block, bound to its top level.
module ipwc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ipwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                rsp_tuser
);
   import ipwc_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a new result only appears after an accepted item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without accepted item");

   // finished items carry no duration and a defined cause
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[TIME_W-1:0] == '0 &&
         rsp_tdata[TIME_W+COUNT_W+CAUSE_W-1:TIME_W+COUNT_W] != 2'd3)
      else $error("bad finished item");

   // duration items report no cause
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[TIME_W+COUNT_W+CAUSE_W-1:TIME_W+COUNT_W] == CAUSE_SIGNAL)
      else $error("duration item with cause");

endmodule

bind ir_pulse_width_capture ipwc_checker u_ipwc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the IR pulse width capture block: stream driver, monitor, predictor.
module tb_top;
   import ipwc_pkg::*;

   // one input item as queued for the driver
   typedef struct {
      opcode_type op;
      logic       level;
   } pin_item_type;

   // one predicted result item
   typedef struct packed {
      kind_type           kind;
      logic [TIME_W-1:0]  duration;
      logic [COUNT_W-1:0] index;
      cause_type          cause;
   } capture_record_type;

   // ------------------------------------------------------------------
   // DUT signals, bench-driven ones known from time zero
   // ------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [0] pin_level, rest zero
   logic                  req_tuser  = 1'b0;  // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [31:0] duration, [42:32] index, [44:43] cause
   logic                  rsp_tuser;          // [0] kind
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index  = CSR_SIGNAL_TIMEOUT;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   always #1 clock = ~clock;

   ir_pulse_width_capture i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   pin_item_type       pin_items[$];        // items waiting for the driver
   capture_record_type capture_records[$];  // predicted results, oldest first
   int unsigned     queued_items  = 0;
   int unsigned     mismatches    = 0;
   int unsigned     send_gap      = 0;
   int unsigned     recv_stall    = 0;
   bit              send_idle_on  = 1'b1;
   bit              recv_stall_on = 1'b1;
   logic            req_taken     = 1'b0;  // handshakes seen at the last rising edge
   logic            rsp_taken     = 1'b0;

   // predictor copy of the configuration
   logic [TIME_W-1:0]  sig_limit   = SIGNAL_TIMEOUT_RST;
   logic [TIME_W-1:0]  pulse_limit = PULSE_TIMEOUT_RST;
   width_code_type     width_code  = WIDTH_HALF;
   logic [COUNT_W-1:0] capacity    = CAPACITY_RST;

   // predictor copy of the capture state
   logic               armed     = 1'b0;
   logic               cur_level = 1'b0;
   logic [TIME_W-1:0]  total_us  = '0;
   logic [TIME_W-1:0]  pulse_us  = '0;
   logic [COUNT_W-1:0] entries   = '0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 50) $display("%0t ns mismatch: %s", $time, msg);
   endtask

   // Advances the capture by one accepted item; queues the record it yields, if any.
   task automatic step_capture(input opcode_type op, input logic level);
      capture_record_type rec;
      logic [COUNT_W-1:0] room;
      bit                 ending;
      rec    = '{kind: KIND_FINISHED, duration: '0, index: entries, cause: CAUSE_SIGNAL};
      room   = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
      ending = 1'b0;
      if (op == OP_ARM) begin
         armed     = 1'b1;
         cur_level = level;
         total_us  = '0;
         pulse_us  = '0;
         entries   = '0;
      end else if (armed) begin
         // both counters stick at all ones
         if (total_us != '1) total_us++;
         if (pulse_us != '1) pulse_us++;
         if (total_us >= sig_limit) begin
            ending    = 1'b1;
            rec.cause = CAUSE_SIGNAL;
         end else if (pulse_us >= pulse_limit) begin
            ending    = 1'b1;
            rec.cause = CAUSE_PULSE;
         end else if (level != cur_level) begin
            if (entries >= room) begin
               ending    = 1'b1;
               rec.cause = CAUSE_FULL;
            end else begin
               rec.kind = KIND_DURATION;
               case (width_code)
                  WIDTH_BYTE: rec.duration = {24'd0, pulse_us[7:0]};
                  WIDTH_HALF: rec.duration = {16'd0, pulse_us[15:0]};
                  default:    rec.duration = pulse_us;  // word and reserved code
               endcase
               capture_records.push_back(rec);
               entries++;
               pulse_us  = '0;
               cur_level = level;
            end
         end
         if (ending) begin
            armed = 1'b0;
            capture_records.push_back(rec);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: presents queued items at the falling edge, random gap after each
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      pin_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (req_tvalid && !req_taken) begin
         // item still on the bus, hold it
      end else if (send_gap != 0) begin
         req_tvalid <= 1'b0;
         send_gap--;
      end else if (pin_items.size() != 0) begin
         it = pin_items.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, it.level};
         req_tuser  <= it.op;
         send_gap = send_idle_on ? $urandom_range(0, 12) : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: after each taken result, stall for a random number of cycles
   always @(negedge clock) begin : receiver
      if (rsp_taken) recv_stall = recv_stall_on ? $urandom_range(0, 12) : 0;
      if (recv_stall != 0) begin
         rsp_tready <= 1'b0;
         recv_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      capture_record_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         // results first: a record predicted at this edge cannot leave before the next one
         if (rsp_tvalid && rsp_tready) begin
            if (capture_records.size() == 0) begin
               report_mismatch($sformatf("result with none pending: tuser %0b tdata %h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = capture_records.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("kind got %0b want %0b", rsp_tuser, want.kind));
               if (rsp_tdata[31:0] !== want.duration)
                  report_mismatch($sformatf("duration got %0d want %0d",
                                            rsp_tdata[31:0], want.duration));
               if (rsp_tdata[42:32] !== want.index)
                  report_mismatch($sformatf("entry index got %0d want %0d",
                                            rsp_tdata[42:32], want.index));
               if (rsp_tdata[44:43] !== want.cause)
                  report_mismatch($sformatf("end cause got %0d want %0d",
                                            rsp_tdata[44:43], want.cause));
               if (rsp_tdata[RSP_DATA_W-1:45] !== '0)
                  report_mismatch($sformatf("tdata padding not zero: %h", rsp_tdata));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIGNAL_TIMEOUT: sig_limit   = csr_data;
               CSR_PULSE_TIMEOUT:  pulse_limit = csr_data;
               CSR_ENTRY_WIDTH:    width_code  = width_code_type'(csr_data[WCODE_W-1:0]);
               CSR_CAPACITY:       capacity    = csr_data[COUNT_W-1:0];
            endcase
         end
         if (req_tvalid && req_tready) step_capture(opcode_type'(req_tuser), req_tdata[0]);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_item(input opcode_type op, input logic level);
      pin_items.push_back('{op, level});
      queued_items++;
   endtask

   // Arm at a start level, then a number of pulses of random length, then ticks
   // with no edge so that a timeout can close the capture.
   task automatic push_capture(input logic start, input int unsigned pulses,
                               input int unsigned max_len, input int unsigned tail);
      logic        lvl;
      int unsigned len;
      lvl = start;
      push_item(OP_ARM, lvl);
      repeat (pulses) begin
         len = $urandom_range(1, max_len);
         repeat (len - 1) push_item(OP_TICK, lvl);
         lvl = ~lvl;
         push_item(OP_TICK, lvl);
      end
      repeat (tail) push_item(OP_TICK, lvl);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold off until every item is sent and every predicted record has arrived,
   // then give the pipe time to settle.
   task automatic drain();
      do @(posedge clock);
      while (pin_items.size() != 0 || req_tvalid || capture_records.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned max_len;
      int unsigned stop_at;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // --- directed, at reset settings: long limits, two-byte entries, 256 entries
      push_item(OP_TICK, 1'b1);  // tick while idle, ignored
      push_item(OP_ARM, 1'b0);
      push_item(OP_TICK, 1'b0);
      push_item(OP_TICK, 1'b1);  // edge, duration 2, entry 0
      push_item(OP_TICK, 1'b0);  // edge, duration 1, entry 1
      push_item(OP_ARM, 1'b1);   // re-arm mid capture, count restarts
      push_item(OP_TICK, 1'b0);
      drain();

      // no buffer room: the first edge ends the capture as full
      write_reg(CSR_CAPACITY, '0);
      push_item(OP_ARM, 1'b0);
      push_item(OP_TICK, 1'b1);
      drain();

      // both limits zero: total limit wins on the first tick
      write_reg(CSR_SIGNAL_TIMEOUT, '0);
      write_reg(CSR_PULSE_TIMEOUT, '0);
      push_item(OP_ARM, 1'b1);
      push_item(OP_TICK, 1'b1);
      push_item(OP_TICK, 1'b0);  // capture already over
      drain();

      // zero pulse limit alone
      write_reg(CSR_SIGNAL_TIMEOUT, '1);
      push_item(OP_ARM, 1'b0);
      push_item(OP_TICK, 1'b0);
      drain();

      // one entry of one byte, pulse limit 3: pulse timeout, then buffer full
      write_reg(CSR_PULSE_TIMEOUT, 32'd3);
      write_reg(CSR_ENTRY_WIDTH, WIDTH_BYTE);
      write_reg(CSR_CAPACITY, 32'd1);
      push_item(OP_ARM, 1'b0);
      repeat (4) push_item(OP_TICK, 1'b1);
      push_item(OP_ARM, 1'b0);
      push_item(OP_TICK, 1'b1);
      push_item(OP_TICK, 1'b0);
      drain();

      // total limit 5 with the reserved width code
      write_reg(CSR_PULSE_TIMEOUT, '1);
      write_reg(CSR_SIGNAL_TIMEOUT, 32'd5);
      write_reg(CSR_ENTRY_WIDTH, WIDTH_RSVD);
      write_reg(CSR_CAPACITY, 32'd256);
      push_item(OP_ARM, 1'b1);
      repeat (5) push_item(OP_TICK, 1'b0);
      drain();

      // --- a full buffer past the clamp, items back to back
      send_idle_on  = 1'b0;
      recv_stall_on = 1'b0;
      write_reg(CSR_SIGNAL_TIMEOUT, '1);
      write_reg(CSR_ENTRY_WIDTH, WIDTH_HALF);
      write_reg(CSR_CAPACITY, 32'd2047);
      push_capture(1'b1, 1030, 1, 0);  // 1024 entries, then full; rest ignored
      drain();

      // --- random phases: fresh settings, idle pattern and capture shapes each time
      while (queued_items < 1850) begin
         case ($urandom_range(0, 3))
            0: max_len = 3;
            1: max_len = 12;
            2: max_len = 40;
            default: max_len = 300;  // pulses past one byte
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(CSR_SIGNAL_TIMEOUT, '1);
            1: write_reg(CSR_SIGNAL_TIMEOUT, $urandom_range(0, 3));
            2: write_reg(CSR_SIGNAL_TIMEOUT, $urandom());
            default: write_reg(CSR_SIGNAL_TIMEOUT, $urandom_range(1, 8 * max_len));
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(CSR_PULSE_TIMEOUT, '1);
            1: write_reg(CSR_PULSE_TIMEOUT, $urandom_range(0, 2));
            2: write_reg(CSR_PULSE_TIMEOUT, $urandom());
            default: write_reg(CSR_PULSE_TIMEOUT, $urandom_range(1, max_len + 5));
         endcase
         write_reg(CSR_ENTRY_WIDTH, $urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_CAPACITY, $urandom_range(1020, 1030));
            1: write_reg(CSR_CAPACITY, $urandom_range(0, 2047));
            default: write_reg(CSR_CAPACITY, $urandom_range(0, 6));
         endcase
         send_idle_on  = ($urandom_range(0, 2) != 0);
         recv_stall_on = ($urandom_range(0, 2) != 0);

         stop_at = queued_items + $urandom_range(60, 140);
         while (queued_items < stop_at) begin
            case ($urandom_range(0, 9))
               // stray item: idle tick or a surprise arm
               0: push_item(opcode_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               // capture cut short by the next arm
               1: push_capture(1'($urandom_range(0, 1)), $urandom_range(0, 2), max_len, 0);
               default: push_capture(1'($urandom_range(0, 1)), $urandom_range(1, 12),
                                     max_len, $urandom_range(0, 2 * max_len));
            endcase
         end
         // sender waits here until every record of the phase is back
         drain();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && capture_records.size() == 0) begin
         $display("ir_pulse_width_capture verification clean");
      end else begin
         $display("ir_pulse_width_capture verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("ir_pulse_width_capture verification failed");
      $finish;
   end

endmodule
